// ===== rtl/octvn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the octave value noise block.
// Holds field widths, register reset values, item and register codes and the
// sequencer state type. Depends on nothing.
package octvn_pkg;

    localparam int COORD_W    = 6;
    localparam int SEED_W     = 16;
    localparam int OCT_CNT_W  = 3;
    localparam int RATIO_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_W     = 15;
    localparam int QUO_W      = 16;
    localparam int STEP_W     = 4;

    localparam logic [OCT_CNT_W-1:0] OCT_CNT_RESET = 3'd5;
    localparam logic [RATIO_W-1:0]   RATIO_RESET   = 16'd16384;
    localparam int                   ONE_Q15       = 32768;
    localparam int                   HALF_Q15      = 16384;

    typedef enum logic
    {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_OCTAVE_COUNT = 1'b0,
        CFG_SCALE_RATIO  = 1'b1
    } cfg_index_t;

    typedef enum logic [9:0]
    {
        ST_IDLE    = 10'b00_0000_0001,
        ST_CORNER  = 10'b00_0000_0010,
        ST_VTOP    = 10'b00_0000_0100,
        ST_VBOT    = 10'b00_0000_1000,
        ST_NORM    = 10'b00_0001_0000,
        ST_WACC    = 10'b00_0010_0000,
        ST_WNEXT   = 10'b00_0100_0000,
        ST_DIVINIT = 10'b00_1000_0000,
        ST_DIV     = 10'b01_0000_0000,
        ST_DONE    = 10'b10_0000_0000
    } state_t;

endpackage

// ===== rtl/octave_value_noise_2d_top.sv =====
`timescale 1ns / 1ps
// Fractal 2-D value noise over a square seed grid held in an internal memory.
// One shared multiplier under a small sequencer, then a bit-serial divider.
// Depends on octvn_pkg.

// Usage
// The input channel carries seed writes (kind = write) and noise queries
// (kind = query); a transaction completes on a rising edge with in_valid high
// and in_stall low. A seed write produces no result. A query of n octaves
// (octave_count clamped to 1..MAX_OCTAVES) keeps in_stall high until its
// result is loaded. Per octave come corner reads overlapped with
// multiply-accumulates, blending and weighting on the shared multiplier with
// a normalising step between, and, in every octave but the last, a step for
// the next weight; then a step that forms the dividend, a restoring division
// at one quotient bit per cycle and a step that loads the output register.
// out_valid rises at the edge where in_stall falls, and no transaction is
// taken before then. While a result waits under out_stall the block still
// takes new transactions; a query finishing before the earlier result is
// taken holds in its final state.
// Configuration writes are accepted in every cycle (cfg_ready is tied high)
// and must only be issued while no query is in flight.
// Reset clears the sequencer and the output valid flag and restores octave_count
// to 5 and scale_ratio to 0.5. The seed memory is not cleared: every grid
// entry must be written before a query reads it. GRID_SIZE must be a power
// of two.
module octave_value_noise_2d_top #(
    parameter int GRID_SIZE   = 64,
    parameter int MAX_OCTAVES = 6
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic [octvn_pkg::COORD_W-1:0]        x,
    input  logic [octvn_pkg::COORD_W-1:0]        y,
    input  logic [octvn_pkg::SEED_W-1:0]         seed_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [octvn_pkg::SEED_W-1:0]         noise_value,
    output logic [octvn_pkg::COORD_W-1:0]        point_x,
    output logic [octvn_pkg::COORD_W-1:0]        point_y,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [octvn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [octvn_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW     = $clog2(GRID_SIZE);
    localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
    localparam int EW     = $clog2(CW + 1);
    localparam int OW     = $clog2(MAX_OCTAVES + 1);
    localparam int TW     = octvn_pkg::SEED_W + CW;
    localparam int BW     = octvn_pkg::SEED_W + 2 * CW;
    localparam int WW     = octvn_pkg::FRAC_W + MAX_OCTAVES;
    localparam int ACW    = octvn_pkg::SEED_W + WW;
    localparam int NW     = ACW + 1;
    localparam int MUL_AW = (TW > WW) ? TW : WW;
    localparam int MUL_BW = octvn_pkg::SEED_W;
    localparam int PW     = MUL_AW + MUL_BW;
    localparam int SW     = octvn_pkg::STEP_W;
    localparam int QW     = octvn_pkg::QUO_W;

    // Seed memory, one write and one registered read port.
    logic [octvn_pkg::SEED_W-1:0] seed_mem [DEPTH];
    logic [octvn_pkg::SEED_W-1:0] rd_data_reg;
    logic [2*CW-1:0]              rd_addr;

    // Control state.
    octvn_pkg::state_t state_reg, state_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [OW-1:0]     oct_reg, oct_next;
    logic [OW-1:0]     noct_reg, noct_next;
    logic              out_valid_reg, out_valid_next;
    logic [octvn_pkg::OCT_CNT_W-1:0] octave_count_reg, octave_count_next;
    logic [octvn_pkg::RATIO_W-1:0]   scale_ratio_reg, scale_ratio_next;

    // Datapath.
    logic [CW-1:0]                px_reg, px_next;
    logic [CW-1:0]                py_reg, py_next;
    logic [octvn_pkg::COORD_W-1:0] qx_reg, qx_next;
    logic [octvn_pkg::COORD_W-1:0] qy_reg, qy_next;
    logic [TW-1:0]                top_reg, top_next;
    logic [TW-1:0]                bot_reg, bot_next;
    logic [BW-1:0]                blend_reg, blend_next;
    logic [octvn_pkg::SEED_W-1:0] v_reg, v_next;
    logic [WW-1:0]                weight_reg, weight_next;
    logic [WW-1:0]                wsum_reg, wsum_next;
    logic [ACW-1:0]               acc_reg, acc_next;
    logic [WW-1:0]                rem_reg, rem_next;
    logic [QW-1:0]                quo_reg, quo_next;
    logic [octvn_pkg::SEED_W-1:0] noise_reg, noise_next;
    logic [octvn_pkg::COORD_W-1:0] point_x_reg, point_x_next;
    logic [octvn_pkg::COORD_W-1:0] point_y_reg, point_y_next;

    // Octave geometry.
    logic [EW-1:0]  pitch_exp;
    logic [EW:0]    shift2;
    logic [CW:0]    pitch;
    logic [CW-1:0]  pmask;
    logic [CW-1:0]  x1, x2, y1, y2, dx, dy;
    logic [CW:0]    cx, cy;
    logic [BW-1:0]  half;
    logic [1:0]     corner_rd, corner_mac;

    // Shared multiplier.
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic [PW-1:0]     product;

    // Divider.
    logic [NW-1:0]  dividend;
    logic [WW:0]    trial;
    logic           trial_ge;

    logic in_fire;
    logic out_free;

    assign in_stall    = (state_reg != octvn_pkg::ST_IDLE);
    assign in_fire     = in_valid && !in_stall;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    // The pitch of octave o is GRID_SIZE >> o, never below one.
    always_comb
    begin
        if (int'(oct_reg) >= CW)
        begin
            pitch_exp = '0;
        end
        else
        begin
            pitch_exp = EW'(CW - int'(oct_reg));
        end
    end

    assign shift2 = {pitch_exp, 1'b0};
    assign pitch  = {{CW{1'b0}}, 1'b1} << pitch_exp;
    assign pmask  = CW'(pitch - {{CW{1'b0}}, 1'b1});
    assign x1     = px_reg & ~pmask;
    assign y1     = py_reg & ~pmask;
    assign dx     = px_reg & pmask;
    assign dy     = py_reg & pmask;
    assign x2     = CW'({1'b0, x1} + pitch);
    assign y2     = CW'({1'b0, y1} + pitch);
    assign cx     = pitch - {1'b0, dx};
    assign cy     = pitch - {1'b0, dy};
    assign half   = (BW'(1) << shift2) >> 1;

    // Corner k is read at step k and multiplied in at step k + 1.
    assign corner_rd  = step_reg[1:0];
    assign corner_mac = 2'(step_reg - SW'(1));
    assign rd_addr    = {(corner_rd[1] ? y2 : y1), (corner_rd[0] ? x2 : x1)};

    always_ff @(posedge clk)
    begin
        if (in_fire && (kind == octvn_pkg::KIND_WRITE))
        begin
            seed_mem[{CW'(y), CW'(x)}] <= seed_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == octvn_pkg::ST_CORNER)
        begin
            rd_data_reg <= seed_mem[rd_addr];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            octvn_pkg::ST_CORNER:
            begin
                mul_a = MUL_AW'(corner_mac[0] ? {1'b0, dx} : cx);
                mul_b = rd_data_reg;
            end
            octvn_pkg::ST_VTOP:
            begin
                mul_a = MUL_AW'(top_reg);
                mul_b = MUL_BW'(cy);
            end
            octvn_pkg::ST_VBOT:
            begin
                mul_a = MUL_AW'(bot_reg);
                mul_b = MUL_BW'(dy);
            end
            octvn_pkg::ST_WACC:
            begin
                mul_a = MUL_AW'(weight_reg);
                mul_b = v_reg;
            end
            octvn_pkg::ST_WNEXT:
            begin
                mul_a = MUL_AW'(weight_reg);
                mul_b = scale_ratio_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = PW'(mul_a) * PW'(mul_b);

    // Rounded dividend; its top part is already below the weight sum.
    assign dividend = NW'(acc_reg) + NW'(wsum_reg >> 1);
    assign trial    = {rem_reg, quo_reg[QW-1]};
    assign trial_ge = (trial >= {1'b0, wsum_reg});

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        oct_next          = oct_reg;
        noct_next         = noct_reg;
        out_valid_next    = out_valid_reg;
        octave_count_next = octave_count_reg;
        scale_ratio_next  = scale_ratio_reg;
        px_next           = px_reg;
        py_next           = py_reg;
        qx_next           = qx_reg;
        qy_next           = qy_reg;
        top_next          = top_reg;
        bot_next          = bot_reg;
        blend_next        = blend_reg;
        v_next            = v_reg;
        weight_next       = weight_reg;
        wsum_next         = wsum_reg;
        acc_next          = acc_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        noise_next        = noise_reg;
        point_x_next      = point_x_reg;
        point_y_next      = point_y_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                octvn_pkg::CFG_OCTAVE_COUNT:
                begin
                    octave_count_next = cfg_data[octvn_pkg::OCT_CNT_W-1:0];
                end
                octvn_pkg::CFG_SCALE_RATIO:
                begin
                    scale_ratio_next = cfg_data[octvn_pkg::RATIO_W-1:0];
                end
                default:
                begin
                    scale_ratio_next = scale_ratio_reg;
                end
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            octvn_pkg::ST_IDLE:
            begin
                if (in_fire && (kind == octvn_pkg::KIND_QUERY))
                begin
                    px_next     = CW'(x);
                    py_next     = CW'(y);
                    qx_next     = x;
                    qy_next     = y;
                    oct_next    = '0;
                    step_next   = '0;
                    weight_next = WW'(octvn_pkg::ONE_Q15);
                    wsum_next   = '0;
                    acc_next    = '0;
                    if (octave_count_reg == '0)
                    begin
                        noct_next = OW'(1);
                    end
                    else if (int'(octave_count_reg) > MAX_OCTAVES)
                    begin
                        noct_next = OW'(MAX_OCTAVES);
                    end
                    else
                    begin
                        noct_next = OW'(octave_count_reg);
                    end
                    state_next = octvn_pkg::ST_CORNER;
                end
            end
            octvn_pkg::ST_CORNER:
            begin
                if (step_reg != '0)
                begin
                    if (!corner_mac[1])
                    begin
                        top_next = corner_mac[0] ? TW'(top_reg + TW'(product)) : TW'(product);
                    end
                    else
                    begin
                        bot_next = corner_mac[0] ? TW'(bot_reg + TW'(product)) : TW'(product);
                    end
                end
                if (step_reg == SW'(4))
                begin
                    state_next = octvn_pkg::ST_VTOP;
                end
                else
                begin
                    step_next = step_reg + SW'(1);
                end
            end
            octvn_pkg::ST_VTOP:
            begin
                blend_next = BW'(product);
                state_next = octvn_pkg::ST_VBOT;
            end
            octvn_pkg::ST_VBOT:
            begin
                blend_next = blend_reg + BW'(product) + half;
                state_next = octvn_pkg::ST_NORM;
            end
            octvn_pkg::ST_NORM:
            begin
                v_next     = octvn_pkg::SEED_W'(blend_reg >> shift2);
                state_next = octvn_pkg::ST_WACC;
            end
            octvn_pkg::ST_WACC:
            begin
                acc_next  = acc_reg + ACW'(product);
                wsum_next = wsum_reg + weight_reg;
                if (oct_reg + OW'(1) == noct_reg)
                begin
                    state_next = octvn_pkg::ST_DIVINIT;
                end
                else
                begin
                    state_next = octvn_pkg::ST_WNEXT;
                end
            end
            octvn_pkg::ST_WNEXT:
            begin
                weight_next = WW'((product + PW'(octvn_pkg::HALF_Q15)) >> octvn_pkg::FRAC_W);
                oct_next    = oct_reg + OW'(1);
                step_next   = '0;
                state_next  = octvn_pkg::ST_CORNER;
            end
            octvn_pkg::ST_DIVINIT:
            begin
                rem_next   = WW'(dividend >> QW);
                quo_next   = dividend[QW-1:0];
                step_next  = '0;
                state_next = octvn_pkg::ST_DIV;
            end
            octvn_pkg::ST_DIV:
            begin
                rem_next  = trial_ge ? WW'(trial - {1'b0, wsum_reg}) : WW'(trial);
                quo_next  = {quo_reg[QW-2:0], trial_ge};
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(QW - 1))
                begin
                    state_next = octvn_pkg::ST_DONE;
                end
            end
            octvn_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    noise_next     = quo_reg;
                    point_x_next   = qx_reg;
                    point_y_next   = qy_reg;
                    out_valid_next = 1'b1;
                    state_next     = octvn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = octvn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= octvn_pkg::ST_IDLE;
            step_reg         <= '0;
            oct_reg          <= '0;
            noct_reg         <= OW'(1);
            out_valid_reg    <= 1'b0;
            octave_count_reg <= octvn_pkg::OCT_CNT_RESET;
            scale_ratio_reg  <= octvn_pkg::RATIO_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            oct_reg          <= oct_next;
            noct_reg         <= noct_next;
            out_valid_reg    <= out_valid_next;
            octave_count_reg <= octave_count_next;
            scale_ratio_reg  <= scale_ratio_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        top_reg     <= top_next;
        bot_reg     <= bot_next;
        blend_reg   <= blend_next;
        v_reg       <= v_next;
        weight_reg  <= weight_next;
        wsum_reg    <= wsum_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        noise_reg   <= noise_next;
        point_x_reg <= point_x_next;
        point_y_reg <= point_y_next;
    end

    // The partial remainder must stay below the divisor, else the quotient
    // would need more than sixteen bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == octvn_pkg::ST_DIV) |-> (rem_reg < wsum_reg))
    else $error("divider remainder not below weight sum");

    // Corner reads only happen for octaves inside the clamped count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == octvn_pkg::ST_CORNER) |-> (oct_reg < noct_reg))
    else $error("octave index beyond octave count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != octvn_pkg::ST_IDLE) |->
        ((noct_reg != '0) && (int'(noct_reg) <= MAX_OCTAVES)))
    else $error("clamped octave count out of range");

    // A finished query must reach the output register when it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == octvn_pkg::ST_DONE) && out_free) |=>
        (out_valid_reg && (state_reg == octvn_pkg::ST_IDLE)))
    else $error("finished query not delivered");

endmodule

// ===== bench/octvn_noise_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the octave value noise block: keeps its own seed grid and
// register copies, predicts each query's noise and compares it with the output.
// Depends on octvn_pkg.
module octvn_noise_checker #(
    parameter int GRID_SIZE   = 64,
    parameter int MAX_OCTAVES = 6
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          kind,
    input  logic [octvn_pkg::COORD_W-1:0] x,
    input  logic [octvn_pkg::COORD_W-1:0] y,
    input  logic [octvn_pkg::SEED_W-1:0]  seed_value,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [octvn_pkg::SEED_W-1:0]  noise_value,
    input  logic [octvn_pkg::COORD_W-1:0] point_x,
    input  logic [octvn_pkg::COORD_W-1:0] point_y,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [octvn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [octvn_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                            answers_pending,
    output int                            mismatch_count
);

    typedef struct packed
    {
        logic [octvn_pkg::SEED_W-1:0]  noise;
        logic [octvn_pkg::COORD_W-1:0] col;
        logic [octvn_pkg::COORD_W-1:0] row;
    } noise_answer_t;

    logic [octvn_pkg::SEED_W-1:0]    seed_grid [GRID_SIZE*GRID_SIZE];
    logic [octvn_pkg::OCT_CNT_W-1:0] octaves_cfg = octvn_pkg::OCT_CNT_RESET;
    logic [octvn_pkg::RATIO_W-1:0]   ratio_cfg   = octvn_pkg::RATIO_RESET;
    noise_answer_t                   answers_due [$];
    noise_answer_t                   due;
    int                              pending = 0;
    int                              mismatches = 0;

    assign answers_pending = pending;
    assign mismatch_count  = mismatches;

    function automatic longint unsigned seed_at(int col, int row);
        return seed_grid[(row % GRID_SIZE) * GRID_SIZE + (col % GRID_SIZE)];
    endfunction

    // Bilinear blend of the four lattice seeds around the point, rounded half up.
    function automatic longint unsigned octave_blend(int px, int py, int pitch);
        int x1, y1, x2, y2;
        longint unsigned p, dx, dy, upper, lower, area;
        x1    = (px / pitch) * pitch;
        y1    = (py / pitch) * pitch;
        x2    = (x1 + pitch) % GRID_SIZE;
        y2    = (y1 + pitch) % GRID_SIZE;
        p     = pitch;
        dx    = px - x1;
        dy    = py - y1;
        upper = (p - dx) * seed_at(x1, y1) + dx * seed_at(x2, y1);
        lower = (p - dx) * seed_at(x1, y2) + dx * seed_at(x2, y2);
        area  = p * p;
        return ((p - dy) * upper + dy * lower + area / 2) / area;
    endfunction

    function automatic logic [octvn_pkg::SEED_W-1:0] fractal_noise(int px, int py);
        int levels, level, pitch;
        longint unsigned weight, weight_sum, blended;
        weight     = octvn_pkg::ONE_Q15;
        weight_sum = 0;
        blended    = 0;
        levels     = octaves_cfg;
        if (levels < 1)
            levels = 1;
        if (levels > MAX_OCTAVES)
            levels = MAX_OCTAVES;
        for (level = 0; level < levels; level++)
        begin
            pitch = GRID_SIZE >> level;
            if (pitch == 0)
                pitch = 1;
            blended    += octave_blend(px, py, pitch) * weight;
            weight_sum += weight;
            weight      = (weight * ratio_cfg + octvn_pkg::HALF_Q15) >> octvn_pkg::FRAC_W;
        end
        return octvn_pkg::SEED_W'((blended + weight_sum / 2) / weight_sum);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octaves_cfg = octvn_pkg::OCT_CNT_RESET;
            ratio_cfg   = octvn_pkg::RATIO_RESET;
            answers_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == octvn_pkg::CFG_OCTAVE_COUNT)
                    octaves_cfg = cfg_data[octvn_pkg::OCT_CNT_W-1:0];
                else if (cfg_index == octvn_pkg::CFG_SCALE_RATIO)
                    ratio_cfg = cfg_data[octvn_pkg::RATIO_W-1:0];
            end
            if (in_valid && !in_stall)
            begin
                if (kind == octvn_pkg::KIND_WRITE)
                    seed_grid[(int'(y) % GRID_SIZE) * GRID_SIZE + int'(x) % GRID_SIZE] =
                        seed_value;
                else
                    answers_due.push_back('{fractal_noise(int'(x) % GRID_SIZE,
                                                          int'(y) % GRID_SIZE), x, y});
            end
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual noise %0d",
                             $time, noise_value);
                    mismatches++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (noise_value !== due.noise)
                    begin
                        $display("%0t: noise_value mismatch: expected %0d, actual %0d",
                                 $time, due.noise, noise_value);
                        mismatches++;
                    end
                    if (point_x !== due.col)
                    begin
                        $display("%0t: point_x mismatch: expected %0d, actual %0d",
                                 $time, due.col, point_x);
                        mismatches++;
                    end
                    if (point_y !== due.row)
                    begin
                        $display("%0t: point_y mismatch: expected %0d, actual %0d",
                                 $time, due.row, point_y);
                        mismatches++;
                    end
                end
            end
        end
        pending = answers_due.size();
    end

endmodule

// ===== bench/tb_octave_value_noise_2d_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the octave value noise block: makes seed writes, noise
// queries and register writes, and gives the verdict. Depends on octvn_pkg,
// octave_value_noise_2d_top and octvn_noise_checker.
module tb_octave_value_noise_2d_top;

    localparam int GRID_SIZE       = 64;
    localparam int MAX_OCTAVES     = 6;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 205;
    // A six-octave query keeps the block busy until its last step loads the output
    // register, and this drain comfortably covers that tail.
    localparam int DRAIN_CYCLES    = 100;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int RATIO_RANDOM    = -1;

    typedef enum int
    {
        STALL_NONE,
        STALL_COIN,
        STALL_HOLD,
        STALL_SPARSE
    } stall_pattern_t;

    // Register settings per phase. Phase 0 runs on the reset values, so its
    // entries are never written. The list takes in an octave count of zero,
    // one above the maximum, a zero ratio and ratios above 1.0.
    int phase_octaves [PHASES] = '{5, 1, 6, 0, 7, 3, 6, 4, 2};
    int phase_ratios  [PHASES] = '{16384, 0, 32768, 65535, 65535, RATIO_RANDOM, 0,
                                   RATIO_RANDOM, 1};

    logic                             clk        = 1'b0;
    logic                             rst_n      = 1'b0;
    logic                             in_valid   = 1'b0;
    logic                             in_stall;
    logic                             kind       = octvn_pkg::KIND_WRITE;
    logic [octvn_pkg::COORD_W-1:0]    x          = '0;
    logic [octvn_pkg::COORD_W-1:0]    y          = '0;
    logic [octvn_pkg::SEED_W-1:0]     seed_value = '0;
    logic                             out_valid;
    logic                             out_stall  = 1'b0;
    logic [octvn_pkg::SEED_W-1:0]     noise_value;
    logic [octvn_pkg::COORD_W-1:0]    point_x;
    logic [octvn_pkg::COORD_W-1:0]    point_y;
    logic                             cfg_valid  = 1'b0;
    logic                             cfg_ready;
    logic [octvn_pkg::CFG_IDX_W-1:0]  cfg_index  = octvn_pkg::CFG_OCTAVE_COUNT;
    logic [octvn_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

    int             answers_pending;
    int             mismatch_count;
    int             cycle_count    = 0;
    int             items_sent     = 0;
    int             burst_left     = 0;
    int             active_octaves = octvn_pkg::OCT_CNT_RESET;
    stall_pattern_t stall_pattern  = STALL_NONE;
    int             stall_left     = 0;

    // Which grid entries have been written so far. A query is only sent once
    // every lattice corner it will read has been written.
    bit seeded [GRID_SIZE*GRID_SIZE];

    octave_value_noise_2d_top #(
        .GRID_SIZE   (GRID_SIZE),
        .MAX_OCTAVES (MAX_OCTAVES)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .x           (x),
        .y           (y),
        .seed_value  (seed_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value),
        .point_x     (point_x),
        .point_y     (point_y),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    octvn_noise_checker #(
        .GRID_SIZE   (GRID_SIZE),
        .MAX_OCTAVES (MAX_OCTAVES)
    ) noise_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .x               (x),
        .y               (y),
        .seed_value      (seed_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .noise_value     (noise_value),
        .point_x         (point_x),
        .point_y         (point_y),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .answers_pending (answers_pending),
        .mismatch_count  (mismatch_count)
    );

    always #1 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The result side stalls on its own pattern: free-running stretches,
    // coin-flip stalls, long holds and occasional single stalls, each for a
    // random number of cycles.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_pattern = stall_pattern_t'($urandom_range(0, 3));
            stall_left    = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_pattern)
            STALL_NONE: out_stall <= 1'b0;
            STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
            STALL_HOLD: out_stall <= 1'b1;
            default:    out_stall <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Seed values lean towards the extremes and the 1.0 point now and then.
    function automatic logic [octvn_pkg::SEED_W-1:0] pick_seed();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return octvn_pkg::SEED_W'(octvn_pkg::ONE_Q15);
            default: return octvn_pkg::SEED_W'($urandom);
        endcase
    endfunction

    // Sends one transaction on the input channel. The sender works in bursts:
    // when a burst runs out, valid may drop for a random gap before the next
    // one starts. Within a burst valid stays high from one transaction to the
    // next, and the payload holds while the block stalls.
    task automatic offer_item(input octvn_pkg::kind_t item_kind, input int col,
                              input int row, input logic [octvn_pkg::SEED_W-1:0] seed);
        int gap;
        int pick;
        if (burst_left == 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick >= 8)
                gap = $urandom_range(20, 100);
            else if (pick >= 4)
                gap = $urandom_range(1, 6);
            else
                gap = 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // An occasional long burst gives stretches with no idling at all.
            burst_left = (pick == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
        end
        in_valid   <= 1'b1;
        kind       <= item_kind;
        x          <= octvn_pkg::COORD_W'(col);
        y          <= octvn_pkg::COORD_W'(row);
        seed_value <= seed;
        if (item_kind == octvn_pkg::KIND_WRITE)
            seeded[(row % GRID_SIZE) * GRID_SIZE + col % GRID_SIZE] = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    // A well-formed query: first write every lattice corner that the current
    // octave count will read and that holds nothing yet, then ask for the point.
    // With use_fill set the missing corners all get fill, else random seeds.
    task automatic query_with_seeds(input int col, input int row, input bit use_fill,
                                    input logic [octvn_pkg::SEED_W-1:0] fill);
        int level, pitch, corner;
        int cols [2];
        int rows [2];
        for (level = 0; level < active_octaves; level++)
        begin
            pitch = GRID_SIZE >> level;
            if (pitch == 0)
                pitch = 1;
            cols[0] = (col / pitch) * pitch;
            cols[1] = (cols[0] + pitch) % GRID_SIZE;
            rows[0] = (row / pitch) * pitch;
            rows[1] = (rows[0] + pitch) % GRID_SIZE;
            for (corner = 0; corner < 4; corner++)
            begin
                if (!seeded[rows[corner / 2] * GRID_SIZE + cols[corner % 2]])
                    offer_item(octvn_pkg::KIND_WRITE, cols[corner % 2], rows[corner / 2],
                               use_fill ? fill : pick_seed());
            end
        end
        offer_item(octvn_pkg::KIND_QUERY, col, row, pick_seed());
    endtask

    // Brings the block to rest: no more input, every answer received, and
    // enough further cycles for any work still under way to finish.
    task automatic drain_block();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (answers_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes both registers back to back while the block is at rest.
    task automatic apply_config(input int octaves, input int ratio);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_index <= octvn_pkg::CFG_OCTAVE_COUNT;
        cfg_data  <= octvn_pkg::CFG_DATA_W'(octaves);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= octvn_pkg::CFG_SCALE_RATIO;
        cfg_data  <= octvn_pkg::CFG_DATA_W'(ratio);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        // The block clamps the count to one at the bottom and to the maximum
        // at the top; the corner pre-writes have to follow the same rule.
        active_octaves = (octaves < 1) ? 1 : (octaves > MAX_OCTAVES) ? MAX_OCTAVES : octaves;
    endtask

    initial
    begin
        int phase;
        int col, row, stride, ratio;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening on the reset register values: coordinate and seed
        // extremes, both transaction kinds, a point whose corners are all at
        // full scale except one at zero, and points whose far corners wrap.
        offer_item(octvn_pkg::KIND_WRITE, 63, 63, '1);
        offer_item(octvn_pkg::KIND_WRITE, 0, 0, '0);
        query_with_seeds(0, 0, 1'b1, '1);
        query_with_seeds(63, 63, 1'b1, '0);
        query_with_seeds(63, 0, 1'b0, '0);
        offer_item(octvn_pkg::KIND_WRITE, 31, 33, pick_seed());

        // Random part, one phase per register setting. Most transactions are
        // queries preceded by the writes they need; the rest are free writes
        // anywhere on the grid, odd entries included, which also overwrite
        // seeds that later queries read.
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                ratio = (phase_ratios[phase] == RATIO_RANDOM) ? $urandom_range(0, 65535)
                                                               : phase_ratios[phase];
                apply_config(phase_octaves[phase], ratio);
            end
            while (items_sent < (phase + 1) * ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 99) < 55)
                begin
                    // A quarter of the queries sit on a coarse lattice, so
                    // that some octaves land exactly on a seed.
                    if ($urandom_range(0, 3) == 0)
                    begin
                        stride = 1 << $urandom_range(1, 5);
                        col    = ($urandom_range(0, GRID_SIZE - 1) / stride) * stride;
                        row    = ($urandom_range(0, GRID_SIZE - 1) / stride) * stride;
                    end
                    else
                    begin
                        col = $urandom_range(0, GRID_SIZE - 1);
                        row = $urandom_range(0, GRID_SIZE - 1);
                    end
                    query_with_seeds(col, row, 1'b0, '0);
                end
                else
                    offer_item(octvn_pkg::KIND_WRITE, $urandom_range(0, GRID_SIZE - 1),
                               $urandom_range(0, GRID_SIZE - 1), pick_seed());
            end
        end

        drain_block();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/octvn_pkg.sv
rtl/octave_value_noise_2d_top.sv
bench/octvn_noise_checker.sv
bench/tb_octave_value_noise_2d_top.sv
